[rtl/core/bqf_pkg.sv]
// Shared types, constants and register indexes of the biquad filter.
package bqf_pkg;

  localparam int SampleW  = 16;
  localparam int CoefW    = 16;
  localparam int DelayW   = 32;
  localparam int ProdW    = CoefW + DelayW;
  localparam int AccW     = 35;
  localparam int ResW     = 5;
  localparam int ShiftW   = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Q15 shift of the high-resolution path and the full sample resolution.
  localparam int HiResShift = 15;
  localparam logic [ResW-1:0] FullRes = ResW'(16);
  localparam logic [ResW-1:0] MinRes  = ResW'(1);

  localparam logic signed [AccW-1:0] SatHi = AccW'(32767);
  localparam logic signed [AccW-1:0] SatLo = -AccW'(32767);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegHighRes = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBitRes  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFbA1    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFbA2    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFwB0    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFwB1    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFwB2    = 3'd6;

  typedef enum logic [3:0] {
    StIdle,
    StMulA1,
    StMulA2,
    StAccA2,
    StMulB0,
    StMulB1,
    StMulB2,
    StAccB2,
    StFinish
  } state_e;

  typedef enum logic [2:0] {
    MulA1W1,
    MulA2W2,
    MulB0W0,
    MulB1W1,
    MulB2W2
  } mul_sel_e;

  typedef enum logic [1:0] {
    AccHold,
    AccSub,
    AccAdd
  } acc_op_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     acc_clear;
    logic     w0_capture;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

[rtl/core/bqf_in_if.sv]
// Input sample channel of the biquad filter.
interface bqf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bqf_pkg::SampleW-1:0]  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

[rtl/core/bqf_out_if.sv]
// Output sample channel of the biquad filter.
interface bqf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bqf_pkg::SampleW-1:0]  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/core/biquad_iir_filter_q15.sv]
// Top level of the second-order direct-form-II IIR filter on Q15 samples.
//
//   channel    dir  handshake            payload
//   in_chan_i  in   valid / ready        sample_in  (16 bit signed)
//   out_chan_o out  valid / ready        sample_out (16 bit signed)
//   cfg        in   cfg_we_i, no ready   cfg_idx_i (3 bit), cfg_data_i (16 bit)
//
// Each item passes through the accept cycle in idle and eight sequencer steps,
// set by the five products going through the single 16x32 multiplier in turn
// and the w0 dependency between the feedback and feedforward halves. The
// output register loads in the Finish step, and the next input item is only
// accepted in idle after that: no new item is taken before the last is done.
// Reset clears the delay words, the output valid and the sequencer, and loads
// the configuration defaults (high resolution, 16 bits, zero coefficients).
// A stalled output holds its item; the next input item is taken meanwhile and
// its last step waits until the output register is free.
module biquad_iir_filter_q15 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bqf_in_if.sink                        in_chan_i,
  bqf_out_if.source                     out_chan_o,
  input  logic                          cfg_we_i,
  input  logic [bqf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bqf_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bqf_pkg::*;

  // Command and status between sequencer and datapath
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  bqf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .in_ready_o (in_chan_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // Configuration registers, multiplier, accumulator, delays and output item
  bqf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (in_chan_i.sample_in),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .out_valid_o  (out_chan_o.valid),
    .out_ready_i  (out_chan_o.ready),
    .sample_out_o (out_chan_o.sample_out)
  );

endmodule

[rtl/core/bqf_ctrl.sv]
// Sequencer of the biquad filter: steps the shared multiplier and accumulator.
module bqf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bqf_pkg::dp_status_t  status_i,
  output bqf_pkg::dp_cmd_t     cmd_o
);
  import bqf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StMulA1;
      StMulA1:  state_d = StMulA2;
      StMulA2:  state_d = StAccA2;
      StAccA2:  state_d = StMulB0;
      StMulB0:  state_d = StMulB1;
      StMulB1:  state_d = StMulB2;
      StMulB2:  state_d = StAccB2;
      StAccB2:  state_d = StFinish;
      StFinish: if (status_i.out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.mul_sel     = MulA1W1;
    cmd_o.acc_op      = AccHold;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StMulA1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulA1W1;
      end
      StMulA2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulA2W2;
        cmd_o.acc_op  = AccSub;
      end
      StAccA2: begin
        cmd_o.acc_op = AccSub;
      end
      StMulB0: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel    = MulB0W0;
        cmd_o.acc_clear  = 1'b1;
        cmd_o.w0_capture = 1'b1;
      end
      StMulB1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulB1W1;
        cmd_o.acc_op  = AccAdd;
      end
      StMulB2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulB2W2;
        cmd_o.acc_op  = AccAdd;
      end
      StAccB2: begin
        cmd_o.acc_op = AccAdd;
      end
      StFinish: begin
        cmd_o.finish = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/bqf_datapath.sv]
// Datapath of the biquad filter: registers, one multiplier, accumulator, delays.
module bqf_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bqf_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [bqf_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic signed [bqf_pkg::SampleW-1:0]    sample_in_i,
  input  bqf_pkg::dp_cmd_t                      cmd_i,
  output bqf_pkg::dp_status_t                   status_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [bqf_pkg::SampleW-1:0]    sample_out_o
);
  import bqf_pkg::*;

  // Configuration registers
  logic                    high_res_q;
  logic [ResW-1:0]         bit_res_q;
  logic signed [CoefW-1:0] a1_q, a2_q, b0_q, b1_q, b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_res_q <= 1'b1;
      bit_res_q  <= FullRes;
      a1_q       <= '0;
      a2_q       <= '0;
      b0_q       <= '0;
      b1_q       <= '0;
      b2_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHighRes: high_res_q <= cfg_data_i[0];
        RegBitRes:  bit_res_q  <= cfg_data_i[ResW-1:0];
        RegFbA1:    a1_q       <= cfg_data_i;
        RegFbA2:    a2_q       <= cfg_data_i;
        RegFwB0:    b0_q       <= cfg_data_i;
        RegFwB1:    b1_q       <= cfg_data_i;
        RegFwB2:    b2_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the resolution, derive the product shift and the output shift.
  logic [ResW-1:0]   res_clamped;
  logic [ShiftW-1:0] shift_amt;
  logic [ShiftW-1:0] up_amt;

  always_comb begin
    if (bit_res_q < MinRes) begin
      res_clamped = MinRes;
    end else if (bit_res_q > FullRes) begin
      res_clamped = FullRes;
    end else begin
      res_clamped = bit_res_q;
    end
    shift_amt = ShiftW'(res_clamped - MinRes);
    up_amt    = ShiftW'(FullRes - res_clamped);
  end

  // Shared multiplier with registered product
  logic signed [DelayW-1:0] w1_q, w2_q, w0_q;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [CoefW-1:0]  mul_a;
  logic signed [DelayW-1:0] mul_b;
  logic signed [ProdW-1:0]  prod_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MulA1W1: begin mul_a = a1_q; mul_b = w1_q; end
      MulA2W2: begin mul_a = a2_q; mul_b = w2_q; end
      MulB0W0: begin mul_a = b0_q; mul_b = acc_q[DelayW-1:0]; end
      MulB1W1: begin mul_a = b1_q; mul_b = w1_q; end
      MulB2W2: begin mul_a = b2_q; mul_b = w2_q; end
      default: begin mul_a = a1_q; mul_b = w1_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Scaled product term: Q15 exact, or wrapped to 32 bits and shifted.
  logic signed [DelayW-1:0] prod_wrap;
  logic signed [DelayW-1:0] prod_sh;
  logic signed [AccW-1:0]   term;

  always_comb begin
    prod_wrap = prod_q[DelayW-1:0];
    prod_sh   = prod_wrap >>> shift_amt;
    if (high_res_q) begin
      term = {{(AccW-ProdW+HiResShift){prod_q[ProdW-1]}}, prod_q[ProdW-1:HiResShift]};
    end else begin
      term = {{(AccW-DelayW){prod_sh[DelayW-1]}}, prod_sh};
    end
  end

  // Accumulator
  logic signed [SampleW-1:0] x_sh;

  always_comb begin
    x_sh  = sample_in_i >>> (high_res_q ? '0 : up_amt);
    acc_d = acc_q;
    if (cmd_i.load) begin
      acc_d = {{(AccW-SampleW){x_sh[SampleW-1]}}, x_sh};
    end else if (cmd_i.acc_clear) begin
      acc_d = '0;
    end else begin
      unique case (cmd_i.acc_op)
        AccSub:  acc_d = acc_q - term;
        AccAdd:  acc_d = acc_q + term;
        AccHold: acc_d = acc_q;
        default: acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.w0_capture) begin
      w0_q <= acc_q[DelayW-1:0];
    end
  end

  // Output scaling and saturation
  logic [DelayW-1:0]         y_up;
  logic signed [AccW-1:0]    y_full;
  logic signed [SampleW-1:0] y_sat;

  always_comb begin
    y_up = acc_q[DelayW-1:0] << up_amt;
    if (high_res_q) begin
      y_full = acc_q;
    end else begin
      y_full = {{(AccW-DelayW){y_up[DelayW-1]}}, y_up};
    end
    if (y_full > SatHi) begin
      y_sat = SatHi[SampleW-1:0];
    end else if (y_full < SatLo) begin
      y_sat = SatLo[SampleW-1:0];
    end else begin
      y_sat = y_full[SampleW-1:0];
    end
  end

  // Delay line and output register
  logic                      out_valid_q;
  logic signed [SampleW-1:0] sample_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q        <= '0;
      w2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        w2_q        <= w1_q;
        w1_q        <= w0_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sample_out_q <= y_sat;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = sample_out_q;

endmodule
